@@ rtl/srts_pkg.sv @@
// Shared types and opcode constants for the sorted record table search block.
`default_nettype none
package srts_pkg;

   // Sort key: ISBN, then book type, then language code; packed order gives the compare order.
   typedef struct packed {
      logic [30:0] isbn;
      logic [1:0]  book_type;
      logic [63:0] lang_code;
   } record_type;

   // Per-cell control from the sequencer.
   typedef struct packed {
      logic cmp_en;
      logic load_en;
      logic occupied;
      logic at_end;
   } cell_ctrl_type;

   localparam logic [1:0] OP_CLEAR  = 2'd0;
   localparam logic [1:0] OP_INSERT = 2'd1;
   localparam logic [1:0] OP_QUERY  = 2'd2;

endpackage
`default_nettype wire

@@ rtl/srts_cell.sv @@
// One table slot: holds a record, compares it against the broadcast key, shifts right on insert.
`default_nettype none
module srts_cell
   import srts_pkg::*;
(
   input  wire logic          clock,
   input  wire cell_ctrl_type ctrl,
   input  wire record_type    key,
   input  wire record_type    left_rec,
   input  wire logic          left_gt,
   output record_type         rec,
   output logic               gt,
   output logic               eq
);

   record_type rec_ff, rec_in;
   logic       gt_ff, gt_in;
   logic       eq_ff, eq_in;

   always_comb begin
      rec_in = rec_ff;
      gt_in  = gt_ff;
      eq_in  = eq_ff;
      if (ctrl.cmp_en) begin
         gt_in = ctrl.occupied && (rec_ff > key);
         eq_in = ctrl.occupied && (rec_ff == key);
      end
      // Slots above the insert point take the left neighbor; the insert point takes the key.
      if (ctrl.load_en && ((ctrl.occupied && gt_ff) || ctrl.at_end)) begin
         rec_in = left_gt ? left_rec : key;
      end
   end

   always_ff @(posedge clock) begin
      rec_ff <= rec_in;
      gt_ff  <= gt_in;
      eq_ff  <= eq_in;
   end

   assign rec = rec_ff;
   assign gt  = gt_ff;
   assign eq  = eq_ff;

endmodule
`default_nettype wire

@@ rtl/srts_or_fold.sv @@
// Match-flag reducer: halves the flag vector by pairwise OR once per cycle.
`default_nettype none
module srts_or_fold
   import srts_pkg::*;
#(
   parameter int unsigned WIDTH = 2
)
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [WIDTH-1:0] flags,
   output logic                  done,
   output logic                  any
);

   localparam int unsigned LOG  = $clog2(WIDTH);
   localparam int unsigned P    = 1 << LOG;
   localparam int unsigned HALF = P / 2;
   localparam int unsigned SW   = $clog2(LOG + 1);

   logic [P-1:0]  v_ff, v_in;
   logic [SW-1:0] left_ff, left_in;

   always_comb begin
      v_in    = v_ff;
      left_in = left_ff;
      if (start) begin
         v_in    = P'(flags);
         left_in = SW'(LOG);
      end else if (left_ff != '0) begin
         v_in = '0;
         for (int j = 0; j < HALF; j++) begin
            v_in[j] = v_ff[2*j] | v_ff[2*j+1];
         end
         left_in = left_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff <= '0;
      end else begin
         left_ff <= left_in;
      end
      v_ff <= v_in;
   end

   assign done = (left_ff == '0);
   assign any  = v_ff[0];

endmodule
`default_nettype wire

@@ rtl/sorted_record_table_search.sv @@
// Sorted record table with exact-match search, built as a chain of record cells.
// Records sit in a row of DEPTH cells kept in ascending order of ISBN, book type and
// language code. In the compare state every cell compares its record with the
// transaction's key; an insert then shifts the cells above the insert point one
// place right in the shift state. A query ORs the per-cell match flags through a
// pairwise fold, one level per cycle, and its result strobe comes once the fold is
// done. A new start is taken only in idle. Clear, a rejected insert on a full table
// and the unused opcode are answered from idle without raising busy. busy is high
// while a transaction is in work; each result appears on the rsp_ ports for exactly
// one cycle with rsp_strobe, and the receiver cannot hold it off.
`default_nettype none
module sorted_record_table_search
   import srts_pkg::*;
#(
   parameter int unsigned DEPTH = 256
)
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [1:0]  req_opcode,
   input  wire logic [30:0] req_isbn,
   input  wire logic [1:0]  req_book_type,
   input  wire logic [63:0] req_lang_code,
   output logic             rsp_strobe,
   output logic             rsp_found,
   output logic             rsp_table_full,
   output logic [8:0]       rsp_entry_count,
   output logic [31:0]      rsp_match_total
);

   localparam int unsigned CW = $clog2(DEPTH + 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_CMP,
      S_SHIFT,
      S_LOAD,
      S_FOLD
   } state_type;

   state_type   state_ff;
   logic [1:0]  op_ff;
   record_type  key_ff;
   logic [CW-1:0] count_ff;
   logic [31:0] total_ff;
   logic        strobe_ff;
   logic        found_ff;
   logic        full_ff;

   record_type       cell_rec [DEPTH];
   logic [DEPTH-1:0] cell_gt;
   logic [DEPTH-1:0] cell_eq;
   logic             fold_done;
   logic             fold_any;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      cell_ctrl_type ctrl;
      record_type    left_rec;
      logic          left_gt;

      always_comb begin
         ctrl.cmp_en   = (state_ff == S_CMP);
         ctrl.load_en  = (state_ff == S_SHIFT);
         ctrl.occupied = (count_ff > CW'(i));
         ctrl.at_end   = (count_ff == CW'(i));
      end

      if (i == 0) begin : g_first
         assign left_rec = key_ff;
         assign left_gt  = 1'b0;
      end else begin : g_next
         assign left_rec = cell_rec[i-1];
         assign left_gt  = cell_gt[i-1];
      end

      srts_cell u_cell (
         .clock    (clock),
         .ctrl     (ctrl),
         .key      (key_ff),
         .left_rec (left_rec),
         .left_gt  (left_gt),
         .rec      (cell_rec[i]),
         .gt       (cell_gt[i]),
         .eq       (cell_eq[i])
      );
   end

   srts_or_fold #(
      .WIDTH (DEPTH)
   ) u_fold (
      .clock (clock),
      .reset (reset),
      .start (state_ff == S_LOAD),
      .flags (cell_eq),
      .done  (fold_done),
      .any   (fold_any)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         count_ff  <= '0;
         total_ff  <= '0;
         strobe_ff <= 1'b0;
         found_ff  <= 1'b0;
         full_ff   <= 1'b0;
      end else begin
         strobe_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (start) begin
                  op_ff            <= req_opcode;
                  key_ff.isbn      <= req_isbn;
                  key_ff.book_type <= req_book_type;
                  key_ff.lang_code <= req_lang_code;
                  found_ff         <= 1'b0;
                  full_ff          <= 1'b0;
                  case (req_opcode)
                     OP_CLEAR: begin
                        count_ff  <= '0;
                        total_ff  <= '0;
                        strobe_ff <= 1'b1;
                     end
                     OP_INSERT: begin
                        if (count_ff == CW'(DEPTH)) begin
                           full_ff   <= 1'b1;
                           strobe_ff <= 1'b1;
                        end else begin
                           state_ff <= S_CMP;
                        end
                     end
                     OP_QUERY: begin
                        state_ff <= S_CMP;
                     end
                     default: begin
                        strobe_ff <= 1'b1;
                     end
                  endcase
               end
            end
            S_CMP: begin
               state_ff <= (op_ff == OP_INSERT) ? S_SHIFT : S_LOAD;
            end
            S_SHIFT: begin
               count_ff  <= count_ff + 1'b1;
               strobe_ff <= 1'b1;
               state_ff  <= S_IDLE;
            end
            S_LOAD: begin
               state_ff <= S_FOLD;
            end
            S_FOLD: begin
               if (fold_done) begin
                  found_ff  <= fold_any;
                  if (fold_any && (total_ff != '1)) begin
                     total_ff <= total_ff + 1'b1;
                  end
                  strobe_ff <= 1'b1;
                  state_ff  <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign busy            = (state_ff != S_IDLE);
   assign rsp_strobe      = strobe_ff;
   assign rsp_found       = found_ff;
   assign rsp_table_full  = full_ff;
   assign rsp_entry_count = 9'(count_ff);
   assign rsp_match_total = total_ff;

`ifndef SYNTH
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result strobe while transaction still in work");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("record count above table depth");

   a_full_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_table_full |-> (count_ff == CW'(DEPTH)))
      else $error("table_full reported with room left");

   a_found_total: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_found) |-> (total_ff != '0))
      else $error("match reported without match count");
`endif

endmodule
`default_nettype wire

@@ dv/sorted_record_table_search_tb.sv @@
// Testbench for the sorted record table search block, checked against a shadow table.
`timescale 1ns / 100ps
module sorted_record_table_search_tb;
   import srts_pkg::*;

   localparam int          DEPTH        = 256;
   localparam logic [1:0]  OP_UNUSED    = 2'd3;
   localparam logic [1:0]  KIND_NEW     = 2'd0;
   localparam logic [1:0]  KIND_USED    = 2'd1;
   localparam logic [1:0]  KIND_DIGITAL = 2'd2;
   localparam logic [1:0]  KIND_EXTRA   = 2'd3;
   localparam int          CYCLE_LIMIT  = 500000;
   localparam int          TAIL_CYCLES  = 20;
   localparam int          MAX_GAP      = 30;
   localparam int          MAX_REPORTS  = 10;

   typedef struct packed {
      logic        found;
      logic        table_full;
      logic [8:0]  entry_count;
      logic [31:0] match_total;
   } outcome_type;

   logic        clock;
   logic        reset         = 1'b1;
   logic        start         = 1'b0;
   logic        busy;
   logic [1:0]  req_opcode    = OP_CLEAR;
   logic [30:0] req_isbn      = '0;
   logic [1:0]  req_book_type = KIND_NEW;
   logic [63:0] req_lang_code = '0;
   logic        rsp_strobe;
   logic        rsp_found;
   logic        rsp_table_full;
   logic [8:0]  rsp_entry_count;
   logic [31:0] rsp_match_total;

   // shadow copy of the table and counters
   record_type  shadow_records [DEPTH];
   int unsigned shadow_count = 0;
   logic [31:0] shadow_hits  = '0;

   outcome_type expected_outcomes[$];
   int unsigned error_count   = 0;
   int unsigned cycle_count   = 0;
   int unsigned n_sent        = 0;
   int unsigned n_inserts     = 0;
   int unsigned n_rejected    = 0;
   int unsigned n_queries     = 0;
   int unsigned n_hits        = 0;
   int unsigned n_clears      = 0;
   int unsigned sender_idle_pct = 0;

   sorted_record_table_search #(.DEPTH(DEPTH)) DUT (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_opcode      (req_opcode),
      .req_isbn        (req_isbn),
      .req_book_type   (req_book_type),
      .req_lang_code   (req_lang_code),
      .rsp_strobe      (rsp_strobe),
      .rsp_found       (rsp_found),
      .rsp_table_full  (rsp_table_full),
      .rsp_entry_count (rsp_entry_count),
      .rsp_match_total (rsp_match_total)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                  expected_outcomes.size());
         $display("end of test: mismatches");
         $finish;
      end
   end

   function automatic record_type make_record(input logic [30:0] isbn, input logic [1:0] kind,
                                              input logic [63:0] lang);
      record_type r;
      r.isbn      = isbn;
      r.book_type = kind;
      r.lang_code = lang;
      return r;
   endfunction

   // Updates the shadow table for one transaction and returns the outcome it should produce.
   function automatic outcome_type apply_to_shadow(input logic [1:0] op, input record_type key);
      outcome_type res;
      int unsigned lo, hi, mid, i;
      res = '0;
      case (op)
         OP_CLEAR: begin
            shadow_count = 0;
            shadow_hits  = '0;
         end
         OP_INSERT: begin
            if (shadow_count >= DEPTH) begin
               res.table_full = 1'b1;
            end else begin
               // upper bound, so duplicates land after their equals
               lo = 0;
               hi = shadow_count;
               while (lo < hi) begin
                  mid = lo + (hi - lo) / 2;
                  if (key < shadow_records[mid]) hi = mid;
                  else lo = mid + 1;
               end
               for (i = shadow_count; i > lo; i--) shadow_records[i] = shadow_records[i - 1];
               shadow_records[lo] = key;
               shadow_count++;
            end
         end
         OP_QUERY: begin
            lo = 0;
            hi = shadow_count;
            while (lo < hi && !res.found) begin
               mid = lo + (hi - lo) / 2;
               if (key == shadow_records[mid]) res.found = 1'b1;
               else if (key < shadow_records[mid]) hi = mid;
               else lo = mid + 1;
            end
            if (res.found && shadow_hits != 32'hFFFF_FFFF) shadow_hits++;
         end
         default: ;
      endcase
      res.entry_count = shadow_count[8:0];
      res.match_total = shadow_hits;
      return res;
   endfunction

   task automatic pause_sender();
      int unsigned gap;
      gap = 0;
      while (gap < MAX_GAP && $urandom_range(0, 99) < sender_idle_pct) gap++;
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Called at a rising edge; returns at the edge where the transaction was taken.
   task automatic send_item(input logic [1:0] op, input record_type key);
      outcome_type res;
      req_opcode    <= op;
      req_isbn      <= key.isbn;
      req_book_type <= key.book_type;
      req_lang_code <= key.lang_code;
      start         <= 1'b1;
      do @(posedge clock); while (busy);
      res = apply_to_shadow(op, key);
      expected_outcomes = {expected_outcomes, res};
      n_sent++;
      case (op)
         OP_CLEAR:  n_clears++;
         OP_INSERT: if (res.table_full) n_rejected++; else n_inserts++;
         OP_QUERY: begin
            n_queries++;
            if (res.found) n_hits++;
         end
         default: ;
      endcase
      pause_sender();
   endtask

   task automatic drain_results();
      start <= 1'b0;
      do @(posedge clock); while (expected_outcomes.size() != 0);
   endtask

   task automatic note_mismatch(input string what, input logic [63:0] want,
                                input logic [63:0] got);
      error_count++;
      if (error_count <= MAX_REPORTS)
         $display("mismatch on %s: expected %0h, got %0h (cycle %0d)", what, want, got,
                  cycle_count);
   endtask

   always @(posedge clock) begin
      outcome_type want;
      if (!reset && rsp_strobe) begin
         if (expected_outcomes.size() == 0) begin
            note_mismatch("unexpected result", '0, 64'd1);
         end else begin
            want = expected_outcomes.pop_front();
            if (rsp_found !== want.found)
               note_mismatch("found", 64'(want.found), 64'(rsp_found));
            if (rsp_table_full !== want.table_full)
               note_mismatch("table_full", 64'(want.table_full), 64'(rsp_table_full));
            if (rsp_entry_count !== want.entry_count)
               note_mismatch("entry_count", 64'(want.entry_count), 64'(rsp_entry_count));
            if (rsp_match_total !== want.match_total)
               note_mismatch("match_total", 64'(want.match_total), 64'(rsp_match_total));
         end
      end
   end

   function automatic record_type random_record();
      record_type r;
      case ($urandom_range(0, 3))
         0:       r.isbn = 31'($urandom_range(0, 7));
         1:       r.isbn = 31'h7FFF_FFFF - 31'($urandom_range(0, 3));
         default: r.isbn = 31'($urandom());
      endcase
      r.book_type = 2'($urandom_range(0, 3));
      case ($urandom_range(0, 6))
         0:       r.lang_code = {"en", 48'd0};
         1:       r.lang_code = {"fr", 48'd0};
         2:       r.lang_code = {"en-US", 24'd0};
         3:       r.lang_code = "zh-Hant_";
         4:       r.lang_code = '0;
         5:       r.lang_code = '1;
         default: r.lang_code = {$urandom(), $urandom()};
      endcase
      return r;
   endfunction

   // Mostly keys already in the table, some near misses, some fresh keys.
   function automatic record_type query_key();
      record_type r;
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (shadow_count == 0 || roll >= 80) return random_record();
      r = shadow_records[$urandom_range(0, shadow_count - 1)];
      if (roll >= 60) begin
         case ($urandom_range(0, 2))
            0:       r.isbn = r.isbn ^ (31'd1 << $urandom_range(0, 30));
            1:       r.book_type = r.book_type ^ 2'($urandom_range(1, 3));
            default: r.lang_code = r.lang_code ^ (64'd1 << $urandom_range(0, 63));
         endcase
      end
      return r;
   endfunction

   task automatic test_empty_table();
      send_item(OP_CLEAR, make_record('0, KIND_NEW, '0));
      send_item(OP_QUERY, make_record('0, KIND_NEW, '0));
      send_item(OP_QUERY, make_record('1, KIND_EXTRA, '1));
   endtask

   task automatic test_ordering_and_duplicates();
      send_item(OP_INSERT, make_record('1, KIND_EXTRA, '1));
      send_item(OP_INSERT, make_record('0, KIND_NEW, '0));
      send_item(OP_INSERT, make_record(31'd5, KIND_USED, {"en", 48'd0}));
      send_item(OP_INSERT, make_record(31'd5, KIND_USED, {"en", 48'd0}));
      send_item(OP_INSERT, make_record(31'd5, KIND_DIGITAL, {"de", 48'd0}));
      send_item(OP_INSERT, make_record(31'd5, KIND_USED, {"de", 48'd0}));
      send_item(OP_INSERT, make_record(31'd5, KIND_EXTRA, {"en", 48'd0}));
      send_item(OP_QUERY,  make_record(31'd5, KIND_USED, {"en", 48'd0}));
      send_item(OP_QUERY,  make_record(31'd5, KIND_USED, {"e", 56'd0}));
      send_item(OP_QUERY,  make_record(31'd5, KIND_EXTRA, {"en", 48'd0}));
      send_item(OP_QUERY,  make_record('1, KIND_EXTRA, '1));
      send_item(OP_QUERY,  make_record('0, KIND_NEW, '0));
      send_item(OP_QUERY,  make_record(31'd5, KIND_NEW, {"en", 48'd0}));
   endtask

   task automatic test_unused_opcode();
      send_item(OP_UNUSED, make_record('1, KIND_EXTRA, '1));
      send_item(OP_UNUSED, make_record('0, KIND_NEW, '0));
      send_item(OP_CLEAR,  make_record('1, KIND_EXTRA, '1));
      send_item(OP_QUERY,  make_record(31'd5, KIND_USED, {"en", 48'd0}));
   endtask

   // Random fill to capacity, then inserts on the full table, queries, unused op, clear.
   task automatic test_fill_to_capacity();
      int unsigned i;
      send_item(OP_CLEAR, random_record());
      for (i = 0; i < DEPTH; i++) send_item(OP_INSERT, random_record());
      drain_results();
      for (i = 0; i < 3; i++) send_item(OP_INSERT, random_record());
      for (i = 0; i < 6; i++) send_item(OP_QUERY, query_key());
      send_item(OP_UNUSED, random_record());
      send_item(OP_CLEAR, random_record());
   endtask

   task automatic test_random_traffic(input int unsigned n_items);
      int unsigned i, roll;
      for (i = 0; i < n_items; i++) begin
         case ((i / 100) % 4)
            0:       sender_idle_pct = 0;
            1:       sender_idle_pct = 64;
            2:       sender_idle_pct = 16;
            default: sender_idle_pct = 0;
         endcase
         roll = $urandom_range(0, 99);
         if (roll < 2)       send_item(OP_CLEAR, random_record());
         else if (roll < 3)  send_item(OP_UNUSED, random_record());
         else if (roll < 48) send_item(OP_INSERT, random_record());
         else                send_item(OP_QUERY, query_key());
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_table();
      test_ordering_and_duplicates();
      test_unused_opcode();
      drain_results();
      sender_idle_pct = 16;
      test_fill_to_capacity();
      drain_results();
      test_random_traffic(760);
      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      error_count += expected_outcomes.size();
      $display("%0d transactions: %0d inserts, %0d rejected as full, %0d queries (%0d hits),",
               n_sent, n_inserts, n_rejected, n_queries, n_hits);
      $display("%0d clears, idle phases of 0/16/64 percent, %0d errors", n_clears, error_count);
      if (error_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

@@ sorted_record_table_search.f @@
rtl/srts_pkg.sv
rtl/srts_cell.sv
rtl/srts_or_fold.sv
rtl/sorted_record_table_search.sv
dv/sorted_record_table_search_tb.sv
